/* design/ptq_pkg.sv */
`default_nettype none
package ptq_pkg;

  // default sizes
  localparam int NUM_TIMERS_DEF = 16;
  localparam int TIME_WIDTH_DEF = 32;

  // a tick fires at most this many slots
  localparam int MAX_RES = 16;
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  // request commands
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_EXPIRED = 3'd1;
  localparam logic [2:0] ST_DELAY   = 3'd2;
  localparam logic [2:0] ST_MISS    = 3'd3;
  localparam logic [2:0] ST_NONE    = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic start_scan;
    logic finish;
    logic flush;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_end;
    logic best_valid;
    logic is_query;
    logic cnt_last;
  } dp_status_t;

endpackage
`default_nettype wire

/* design/ptq_ram.sv */
`default_nettype none
module ptq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/ptq_ctrl.sv */
`default_nettype none
module ptq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [1:0]           in_command,
  input  wire ptq_pkg::dp_status_t  status,
  output logic                      busy,
  output ptq_pkg::ctrl_cmd_t        cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FIN   = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       scan_cmd;
  logic       rescan;

  assign busy     = (state_r != S_IDLE);
  assign scan_cmd = (in_command == ptq_pkg::CMD_TICK) ||
                    (in_command == ptq_pkg::CMD_QUERY);
  assign rescan   = (state_r == S_FIN) && !status.is_query &&
                    status.best_valid && !status.cnt_last;

  // issue commands
  always_comb begin
    cmd.accept     = start && !busy;
    cmd.start_scan = (start && !busy && scan_cmd) || rescan;
    cmd.finish     = (state_r == S_FIN);
    cmd.flush      = (state_r == S_FLUSH);
  end

  // sequence the scans
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start && scan_cmd) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (status.scan_end) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (status.is_query || !status.best_valid) state_nxt = S_IDLE;
        else if (status.cnt_last) state_nxt = S_FLUSH;
        else state_nxt = S_SCAN;
      end
      S_FLUSH: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // the scan end may only come while scanning
  a_end_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    status.scan_end |-> state_r == S_SCAN)
    else $error("scan end outside scan");

endmodule
`default_nettype wire

/* design/ptq_dp.sv */
`default_nettype none
module ptq_dp #(
  parameter int NUM_TIMERS = ptq_pkg::NUM_TIMERS_DEF,
  parameter int TIME_WIDTH = ptq_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ptq_pkg::ctrl_cmd_t   cmd,
  input  wire logic [1:0]           in_command,
  input  wire logic [3:0]           in_timer_slot,
  input  wire logic [31:0]          in_period_ms,
  input  wire logic                 in_repeat_req,
  input  wire logic [31:0]          in_now_ms,
  output ptq_pkg::dp_status_t       status,
  output logic                      out_valid,
  output logic [2:0]                out_status,
  output logic [3:0]                out_expired_slot,
  output logic [31:0]               out_next_delay_ms,
  output logic                      out_last
);

  localparam int SW = $clog2(NUM_TIMERS);
  localparam int TW = TIME_WIDTH;
  localparam int DW = (TW > 32) ? TW : 32;
  localparam logic [SW-1:0] LAST_IDX = SW'(NUM_TIMERS - 1);

  logic [NUM_TIMERS-1:0] armed_r, picked_r, rep_r;
  logic [TW-1:0]  now_r;
  logic           is_query_r;
  logic [ptq_pkg::CNT_W-1:0] cnt_r;

  logic [SW-1:0]  rd_addr_r, cmp_idx_r;
  logic           scan_r, cmp_valid_r;
  logic [TW-1:0]  dl_q, per_q;

  logic           best_valid_r;
  logic [SW-1:0]  best_idx_r;
  logic [TW-1:0]  best_dl_r, best_per_r;

  logic           pend_valid_r;
  logic [SW-1:0]  pend_idx_r;

  logic           out_valid_r, out_last_r;
  logic [2:0]     out_status_r;
  logic [3:0]     out_slot_r;
  logic [31:0]    out_delay_r;

  logic [TW-1:0]  now_in, per_in;
  logic           in_range;
  logic [SW-1:0]  in_idx;
  logic           is_add, is_del, fire;
  logic           dl_we;
  logic [SW-1:0]  dl_waddr;
  logic [TW-1:0]  dl_wdata;
  logic           cand;
  logic [TW-1:0]  diff;
  logic [DW-1:0]  diff_ext;
  logic [31:0]    delay;

  assign now_in   = TW'(in_now_ms);
  assign per_in   = TW'(in_period_ms);
  assign in_range = 32'(in_timer_slot) < NUM_TIMERS;
  assign in_idx   = SW'(in_timer_slot);
  assign is_add   = cmd.accept && (in_command == ptq_pkg::CMD_ADD) && in_range;
  assign is_del   = cmd.accept && (in_command == ptq_pkg::CMD_DELETE);
  assign fire     = cmd.finish && !is_query_r && best_valid_r;

  // share one write port between add and rearm
  assign dl_we    = is_add || (fire && rep_r[best_idx_r]);
  assign dl_waddr = is_add ? in_idx : best_idx_r;
  assign dl_wdata = is_add ? (now_in + per_in) : (now_r + best_per_r);

  ptq_ram #(.WIDTH(TW), .DEPTH(NUM_TIMERS)) u_deadline (
    .clk(clk), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
    .raddr(rd_addr_r), .rdata(dl_q)
  );

  ptq_ram #(.WIDTH(TW), .DEPTH(NUM_TIMERS)) u_period (
    .clk(clk), .we(is_add), .waddr(in_idx), .wdata(per_in),
    .raddr(rd_addr_r), .rdata(per_q)
  );

  // candidate for the running minimum
  assign cand = cmp_valid_r && armed_r[cmp_idx_r] &&
                (is_query_r || (!picked_r[cmp_idx_r] && dl_q <= now_r));

  // query delay, saturated to the port width
  assign diff     = best_dl_r - now_r;
  assign diff_ext = DW'(diff);
  always_comb begin
    if (!best_valid_r) delay = '1;
    else if (best_dl_r <= now_r) delay = '0;
    else if (diff_ext > DW'(32'hFFFF_FFFF)) delay = '1;
    else delay = 32'(diff_ext);
  end

  always_comb begin
    status.scan_end   = cmp_valid_r && (cmp_idx_r == LAST_IDX);
    status.best_valid = best_valid_r;
    status.is_query   = is_query_r;
    status.cnt_last   = (cnt_r == ptq_pkg::CNT_W'(ptq_pkg::MAX_RES - 1));
  end

  // scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= 1'b0;
      cmp_valid_r <= 1'b0;
      rd_addr_r   <= '0;
    end else begin
      cmp_valid_r <= scan_r;
      if (cmd.start_scan) begin
        scan_r    <= 1'b1;
        rd_addr_r <= '0;
      end else if (scan_r) begin
        if (rd_addr_r == LAST_IDX) scan_r <= 1'b0;
        else rd_addr_r <= rd_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= rd_addr_r;
  end

  // track the earliest candidate, lower slot on ties
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
    end else if (cmd.start_scan) begin
      best_valid_r <= 1'b0;
    end else if (cand && (!best_valid_r || dl_q < best_dl_r)) begin
      best_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cand && (!best_valid_r || dl_q < best_dl_r)) begin
      best_idx_r <= cmp_idx_r;
      best_dl_r  <= dl_q;
      best_per_r <= per_q;
    end
  end

  // slot flags, request context and fired count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r      <= '0;
      picked_r     <= '0;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      is_query_r   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        is_query_r   <= (in_command == ptq_pkg::CMD_QUERY);
        picked_r     <= '0;
        cnt_r        <= '0;
        pend_valid_r <= 1'b0;
      end
      if (is_add) armed_r[in_idx] <= 1'b1;
      if (is_del && in_range) armed_r[in_idx] <= 1'b0;
      if (fire) begin
        picked_r[best_idx_r] <= 1'b1;
        if (!rep_r[best_idx_r]) armed_r[best_idx_r] <= 1'b0;
        cnt_r        <= cnt_r + 1'b1;
        pend_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) now_r <= now_in;
    if (is_add) rep_r[in_idx] <= in_repeat_req;
    if (fire) pend_idx_r <= best_idx_r;
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.accept && !(in_command == ptq_pkg::CMD_TICK ||
                                      in_command == ptq_pkg::CMD_QUERY)) ||
                     (cmd.finish && (is_query_r || !best_valid_r || pend_valid_r)) ||
                     cmd.flush;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_slot_r  <= '0;
    out_delay_r <= '0;
    out_last_r  <= 1'b1;
    out_status_r <= ptq_pkg::ST_DONE;
    if (is_del) begin
      out_status_r <= (in_range && armed_r[in_idx]) ? ptq_pkg::ST_DONE : ptq_pkg::ST_MISS;
    end else if (cmd.finish && is_query_r) begin
      out_status_r <= ptq_pkg::ST_DELAY;
      out_delay_r  <= delay;
    end else if (cmd.finish || cmd.flush) begin
      if (pend_valid_r) begin
        out_status_r <= ptq_pkg::ST_EXPIRED;
        out_slot_r   <= 4'(pend_idx_r);
        out_last_r   <= cmd.flush || !best_valid_r;
      end else begin
        out_status_r <= ptq_pkg::ST_NONE;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_expired_slot  = out_slot_r;
  assign out_next_delay_ms = out_delay_r;
  assign out_last          = out_last_r;

  a_scan_stops: assert property (@(posedge clk) disable iff (!rst_n)
    status.scan_end |=> !cmp_valid_r)
    else $error("scan ran past last slot");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ptq_pkg::CNT_W'(ptq_pkg::MAX_RES))
    else $error("fired count beyond limit");

  a_fired_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ptq_pkg::ST_EXPIRED |-> cnt_r != '0)
    else $error("expiry without a fired slot");

endmodule
`default_nettype wire

/* design/periodic_timer_queue.sv */
`default_nettype none
// Channel  | Ports                                           | Handshake
// request  | in_command in_timer_slot in_period_ms           | start && !busy
//          | in_repeat_req in_now_ms                         |
// result   | out_status out_expired_slot out_next_delay_ms   | out_valid, one cycle
//          | out_last                                        |
//
// Add and delete do not make the block busy; the result follows on the next cycle.
// A query makes one pass of the slot scan, one slot a
// cycle through the registered read of the deadline memory.
// A tick runs one scan per fired slot and a last scan that finds none; a tick
// that fires 16 slots ends with the flush state in place of that last scan.
// Synchronous active-low reset disarms every slot; no clearing pass.
// The receiver cannot stall: each result shows for exactly one cycle.
module periodic_timer_queue #(
  parameter int NUM_TIMERS = ptq_pkg::NUM_TIMERS_DEF,
  parameter int TIME_WIDTH = ptq_pkg::TIME_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_command,
  input  wire logic [3:0]  in_timer_slot,
  input  wire logic [31:0] in_period_ms,
  input  wire logic        in_repeat_req,
  input  wire logic [31:0] in_now_ms,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [3:0]       out_expired_slot,
  output logic [31:0]      out_next_delay_ms,
  output logic             out_last
);

  ptq_pkg::ctrl_cmd_t  cmd;
  ptq_pkg::dp_status_t status;

  ptq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_command(in_command),
    .status(status), .busy(busy), .cmd(cmd)
  );

  ptq_dp #(.NUM_TIMERS(NUM_TIMERS), .TIME_WIDTH(TIME_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_command(in_command),
    .in_timer_slot(in_timer_slot), .in_period_ms(in_period_ms),
    .in_repeat_req(in_repeat_req), .in_now_ms(in_now_ms), .status(status),
    .out_valid(out_valid), .out_status(out_status),
    .out_expired_slot(out_expired_slot), .out_next_delay_ms(out_next_delay_ms),
    .out_last(out_last)
  );

endmodule
`default_nettype wire
